// File: hw/rtl/rad_pkg.sv
// Shared types and constants for the reaction-advection-diffusion stencil.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rad_pkg;

    localparam int DENS_W  = 32;   // density word, unsigned Q.16
    localparam int IDX_W   = 12;   // grid index
    localparam int COEF_W  = 32;   // Q2.30 coefficients
    localparam int POS_W   = 32;   // signed Q16.16 position
    localparam int CFG_A_W = 3;
    localparam int MUL_W   = 35;   // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 56;

    // Register map
    localparam logic [CFG_A_W-1:0] REG_LAST_INDEX = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GROWTH     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_INV_CAP    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DRIFT      = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ADVECT     = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DIFFUSION  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_GRID_STEP  = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_ORIGIN     = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]         last_index;
        logic signed [COEF_W-1:0] growth_coef;
        logic signed [COEF_W-1:0] inv_capacity;
        logic signed [COEF_W-1:0] drift_coef;
        logic signed [COEF_W-1:0] advect_coef;
        logic signed [COEF_W-1:0] diffusion_coef;
        logic [30:0]              grid_step;
        logic signed [POS_W-1:0]  origin;
    } rad_cfg_t;

    // One queued item of work for the back end
    typedef struct packed {
        logic                    has_main;   // emit a point before any boundary
        logic                    main_calc;  // main point is interior: run the update
        logic [IDX_W-1:0]        main_idx;
        logic                    main_last;
        logic                    has_bnd;    // emit the closing boundary point
        logic [IDX_W-1:0]        bnd_idx;
        logic [DENS_W-1:0]       ul;
        logic [DENS_W-1:0]       uc;
        logic [DENS_W-1:0]       ur;
        logic signed [POS_W-1:0] pos;
    } rad_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
        ST_MAIN, ST_BND
    } rad_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rad_front.sv
// Front end: accepts densities, keeps the three-point window, grid counter
// and position, and turns each item into a work command. Uses rad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rad_front
    import rad_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rad_cfg_t          cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DENS_W-1:0] density,
    output logic                   push,
    output rad_cmd_t               cmd,
    input  wire logic              q_full
);

    logic [DENS_W-1:0]       win0_reg, win1_reg;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    acc, sweep_end;
    logic signed [POS_W:0]   pos_sum, neg_org;

    assign in_ready  = !q_full;
    assign acc       = in_valid && in_ready;
    assign sweep_end = (cnt_reg >= cfg.last_index);

    // Work out position and command
    always_comb
    begin
        neg_org  = -{cfg.origin[POS_W-1], cfg.origin};
        pos_sum  = {pos_reg[POS_W-1], pos_reg} + {2'b00, cfg.grid_step};
        pos_next = pos_reg;
        if (cnt_reg == '0)
        begin
            pos_next = (neg_org[POS_W] != neg_org[POS_W-1]) ?
                       {1'b0, {(POS_W-1){1'b1}}} : neg_org[POS_W-1:0];
        end
        else if (cnt_reg >= IDX_W'(2))
        begin
            pos_next = (pos_sum[POS_W] != pos_sum[POS_W-1]) ?
                       {1'b0, {(POS_W-1){1'b1}}} : pos_sum[POS_W-1:0];
        end
        cnt_next = sweep_end ? '0 : cnt_reg + IDX_W'(1);

        cmd.has_main  = (cnt_reg == '0) || (cnt_reg >= IDX_W'(2));
        cmd.main_calc = (cnt_reg >= IDX_W'(2));
        cmd.main_idx  = (cnt_reg == '0) ? '0 : cnt_reg - IDX_W'(1);
        cmd.main_last = (cnt_reg == '0) && sweep_end;
        cmd.has_bnd   = (cnt_reg != '0) && sweep_end;
        cmd.bnd_idx   = cnt_reg;
        cmd.ul        = win1_reg;
        cmd.uc        = win0_reg;
        cmd.ur        = density;
        cmd.pos       = pos_next;
        push          = acc && (cmd.has_main || cmd.has_bnd);
    end

    // Advance counter and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pos_reg  <= '0;
            win0_reg <= '0;
            win1_reg <= '0;
        end
        else if (acc)
        begin
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            win1_reg <= win0_reg;
            win0_reg <= density;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rad_queue.sv
// Two-entry command queue between front and back end. Uses rad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rad_queue
    import rad_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire rad_cmd_t wr_cmd,
    output logic          full,
    output logic          not_empty,
    input  wire logic     pop,
    output rad_cmd_t      rd_cmd
);

    rad_cmd_t   slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rd_cmd    = slot_reg[rp_reg];

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_cmd;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rad_back.sv
// Back end: runs the point update on one shared multiplier over eight steps
// and drives the result register. Uses rad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rad_back
    import rad_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rad_cfg_t          cfg,
    input  wire logic              q_valid,
    input  wire rad_cmd_t          q_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DENS_W-1:0]      new_density,
    output logic [IDX_W-1:0]       point_index,
    output logic                   clamped,
    output logic                   last_of_sweep
);

    rad_state_t                state_reg, state_next;
    rad_cmd_t                  cmd_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MUL_W-1:0]   omk_reg, omk_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [MUL_W-1:0]   sh30, c_s, ul_s, ur_s;
    logic signed [ACC_W-1:0]   t16, t30;
    logic                      ov_reg, ov_next, out_free, load_out;
    logic [DENS_W-1:0]         val_next;
    logic [IDX_W-1:0]          idx_next;
    logic                      clp_next, last_next;

    assign out_free  = !ov_reg || out_ready;
    assign c_s       = MUL_W'({1'b0, cmd_reg.uc});
    assign ul_s      = MUL_W'({1'b0, cmd_reg.ul});
    assign ur_s      = MUL_W'({1'b0, cmd_reg.ur});
    assign sh30      = prod_reg[MUL_W+29:30];
    assign t16       = ACC_W'($signed(prod_reg[PROD_W-1:16]));
    assign t30       = ACC_W'($signed(prod_reg[PROD_W-1:30]));

    // Sequence the update and the emits
    always_comb
    begin
        state_next = state_reg;
        omk_next   = omk_reg;
        acc_next   = acc_reg;
        mul_a      = '0;
        mul_b      = '0;
        pop        = 1'b0;
        load_out   = 1'b0;
        val_next   = '0;
        idx_next   = cmd_reg.main_idx;
        clp_next   = 1'b0;
        last_next  = cmd_reg.main_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_cmd.main_calc)
                        state_next = ST_C0;
                    else if (q_cmd.has_main)
                        state_next = ST_MAIN;
                    else
                        state_next = ST_BND;
                end
            end
            ST_C0:
            begin
                mul_a = c_s;
                mul_b = MUL_W'(cfg.inv_capacity);
                state_next = ST_C1;
            end
            ST_C1:
            begin
                omk_next = MUL_W'(65536) - sh30;
                mul_a = MUL_W'(cfg.growth_coef);
                mul_b = c_s;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                mul_a = sh30;
                mul_b = omk_reg;
                state_next = ST_C3;
            end
            ST_C3:
            begin
                acc_next = ACC_W'(c_s) + t16;
                mul_a = MUL_W'(cfg.drift_coef);
                mul_b = c_s;
                state_next = ST_C4;
            end
            ST_C4:
            begin
                acc_next = acc_reg + t30;
                mul_a = MUL_W'(cfg.advect_coef);
                mul_b = MUL_W'(cmd_reg.pos);
                state_next = ST_C5;
            end
            ST_C5:
            begin
                mul_a = sh30;
                mul_b = ur_s - ul_s;
                state_next = ST_C6;
            end
            ST_C6:
            begin
                acc_next = acc_reg + t16;
                mul_a = MUL_W'(cfg.diffusion_coef);
                mul_b = ur_s + ul_s - (c_s <<< 1);
                state_next = ST_C7;
            end
            ST_C7:
            begin
                acc_next = acc_reg + t30;
                state_next = ST_MAIN;
            end
            ST_MAIN:
            begin
                if (cmd_reg.main_calc)
                begin
                    if (acc_reg < 0)
                        clp_next = 1'b1;
                    else if (acc_reg > ACC_W'({DENS_W{1'b1}}))
                        val_next = {DENS_W{1'b1}};
                    else
                        val_next = acc_reg[DENS_W-1:0];
                end
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = cmd_reg.has_bnd ? ST_BND : ST_IDLE;
                end
            end
            ST_BND:
            begin
                idx_next  = cmd_reg.bnd_idx;
                last_next = 1'b1;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ov_next = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    // Hold command, multiplier product and sums
    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= q_cmd;
        prod_reg <= mul_a * mul_b;
        omk_reg  <= omk_next;
        acc_reg  <= acc_next;
        if (load_out)
        begin
            new_density   <= val_next;
            point_index   <= idx_next;
            clamped       <= clp_next;
            last_of_sweep <= last_next;
        end
    end

    // Advance state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule
`default_nettype wire

// File: hw/rtl/reaction_advection_diffusion_stencil.sv
// Top level of the stencil: configuration registers, front end, command
// queue and back end. Uses rad_pkg, rad_front, rad_queue and rad_back.
//
// One explicit time step of a 1-D reaction-advection-diffusion grid over a
// stream of densities, points 0 to N. In the back end each interior point
// takes the command, runs eight steps around one shared 35x35 multiplier with
// seven products, then writes the result; a boundary point on its own is taken
// and written, and the closing boundary after an interior point adds one more
// write. The front end takes an item per cycle while its two-entry queue
// has room, so sustained rate is set by the back end, and falls while results
// are stalled. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none
module reaction_advection_diffusion_stencil
    import rad_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DENS_W-1:0]  density,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DENS_W-1:0]       new_density,
    output logic [IDX_W-1:0]        point_index,
    output logic                    clamped,
    output logic                    last_of_sweep
);

    rad_cfg_t cfg_reg;
    rad_cmd_t push_cmd, pop_cmd;
    logic     push, pop, q_full, q_valid;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg            <= '0;
            cfg_reg.last_index <= {IDX_W{1'b1}};
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LAST_INDEX: cfg_reg.last_index     <= cfg_data[IDX_W-1:0];
                REG_GROWTH:     cfg_reg.growth_coef    <= cfg_data;
                REG_INV_CAP:    cfg_reg.inv_capacity   <= cfg_data;
                REG_DRIFT:      cfg_reg.drift_coef     <= cfg_data;
                REG_ADVECT:     cfg_reg.advect_coef    <= cfg_data;
                REG_DIFFUSION:  cfg_reg.diffusion_coef <= cfg_data;
                REG_GRID_STEP:  cfg_reg.grid_step      <= cfg_data[30:0];
                REG_ORIGIN:     cfg_reg.origin         <= cfg_data;
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    rad_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .density  (density),
        .push     (push),
        .cmd      (push_cmd),
        .q_full   (q_full)
    );

    rad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (push_cmd),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (pop),
        .rd_cmd    (pop_cmd)
    );

    rad_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_density   (new_density),
        .point_index   (point_index),
        .clamped       (clamped),
        .last_of_sweep (last_of_sweep)
    );

endmodule
`default_nettype wire

// File: hw/rtl/rad_checker.sv
// Port-level checks for the stencil, bound to the top level.
// Depends on rad_pkg and reaction_advection_diffusion_stencil.
`timescale 1ns / 1ps
`default_nettype none
module rad_checker
    import rad_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DENS_W-1:0] new_density,
    input wire logic [IDX_W-1:0]  point_index,
    input wire logic              clamped,
    input wire logic              last_of_sweep
);

    // Held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_density)
        && $stable(point_index))
        else $error("result changed while stalled");

    // Clamped points read zero
    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> new_density == '0)
        else $error("clamped point not zero");

    // Boundary at sweep end is zero and never clamped
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_sweep |-> new_density == '0 && !clamped)
        else $error("end boundary not zero");

    // Point zero is a boundary
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_index == '0 |-> new_density == '0 && !clamped)
        else $error("point zero not zero");

endmodule

bind reaction_advection_diffusion_stencil rad_checker u_rad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_density   (new_density),
    .point_index   (point_index),
    .clamped       (clamped),
    .last_of_sweep (last_of_sweep)
);
`default_nettype wire

// File: bench/tb_reaction_advection_diffusion_stencil.sv
// Self-checking testbench for the reaction-advection-diffusion stencil.
// Depends on rad_pkg and reaction_advection_diffusion_stencil only.
`timescale 1ns / 1ps
module tb_reaction_advection_diffusion_stencil;
    import rad_pkg::*;

    localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 60;

    typedef struct {
        logic [DENS_W-1:0] dens;
        logic [IDX_W-1:0]  idx;
        logic              clp;
        logic              last;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = REG_LAST_INDEX;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [DENS_W-1:0] density = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [DENS_W-1:0] new_density;
    logic [IDX_W-1:0] point_index;
    logic clamped;
    logic last_of_sweep;

    // Predictor copy of the registers and the sweep state
    logic [IDX_W-1:0]  m_last;
    logic signed [63:0] m_growth, m_invcap, m_drift, m_advect, m_diff, m_step, m_origin;
    logic [DENS_W-1:0] m_prev, m_prev2;
    logic [IDX_W-1:0]  m_count;
    logic signed [63:0] m_pos;

    point_t expected_points[$];
    int errors = 0;
    int items_sent = 0;
    int points_checked = 0;
    int clamps_seen = 0;
    int sweeps_seen = 0;
    longint cycles = 0;
    bit calm = 1'b0;

    reaction_advection_diffusion_stencil dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .density(density),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_density(new_density), .point_index(point_index),
        .clamped(clamped), .last_of_sweep(last_of_sweep)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Saturate to the intermediate range
    function automatic logic signed [63:0] sat62(input logic signed [127:0] v);
        if (v > SAT_LIM) return SAT_LIM;
        if (v < -SAT_LIM) return -SAT_LIM;
        return v[63:0];
    endfunction

    // Exact product, floor shift, saturate
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b, input int sh);
        logic signed [127:0] wa, wb, p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> sh;
        return sat62(p);
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return sat62(wa + wb);
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // Work out the updated points caused by one arriving density
    task automatic predict_density(input logic [DENS_W-1:0] d);
        logic signed [63:0] ul, c, ur, q, omk, gu, total;
        point_t p;
        ul = {32'd0, m_prev2};
        c = {32'd0, m_prev};
        ur = {32'd0, d};
        if (m_count == 0)
        begin
            m_pos = clip32(-m_origin);
            p = '{0, 0, 1'b0, m_last == 0};
            expected_points.push_back(p);
        end
        else if (m_count >= 2)
        begin
            m_pos = clip32(m_pos + m_step);
            q = fx_mul(c, m_invcap, 30);
            omk = fx_add(64'sd65536, -q);
            gu = fx_mul(m_growth, c, 30);
            total = c;
            total = fx_add(total, fx_mul(gu, omk, 16));
            total = fx_add(total, fx_mul(m_drift, c, 30));
            total = fx_add(total, fx_mul(fx_mul(m_advect, m_pos, 30), ur - ul, 16));
            total = fx_add(total, fx_mul(m_diff, ur + ul - 2 * c, 30));
            if (total < 0)
                p = '{0, m_count - 1, 1'b1, 1'b0};
            else if (total > 64'sh0_FFFF_FFFF)
                p = '{32'hFFFF_FFFF, m_count - 1, 1'b0, 1'b0};
            else
                p = '{total[31:0], m_count - 1, 1'b0, 1'b0};
            expected_points.push_back(p);
        end
        if (m_count >= 1 && m_count >= m_last)
        begin
            p = '{0, m_count, 1'b0, 1'b1};
            expected_points.push_back(p);
        end
        m_count = (m_count >= m_last) ? '0 : m_count + 1;
        m_prev2 = m_prev;
        m_prev = d;
    endtask

    // Write one register; caller is at a rising edge
    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_LAST_INDEX: m_last = val[IDX_W-1:0];
            REG_GROWTH:     m_growth = $signed(val);
            REG_INV_CAP:    m_invcap = $signed(val);
            REG_DRIFT:      m_drift = $signed(val);
            REG_ADVECT:     m_advect = $signed(val);
            REG_DIFFUSION:  m_diff = $signed(val);
            REG_GRID_STEP:  m_step = {33'd0, val[30:0]};
            REG_ORIGIN:     m_origin = $signed(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] n, input logic [31:0] g, input logic [31:0] ik,
                             input logic [31:0] dr, input logic [31:0] ad,
                             input logic [31:0] df, input logic [31:0] st,
                             input logic [31:0] org);
        write_reg(REG_LAST_INDEX, n);
        write_reg(REG_GROWTH, g);
        write_reg(REG_INV_CAP, ik);
        write_reg(REG_DRIFT, dr);
        write_reg(REG_ADVECT, ad);
        write_reg(REG_DIFFUSION, df);
        write_reg(REG_GRID_STEP, st);
        write_reg(REG_ORIGIN, org);
    endtask

    // Send one density item, with an occasional random gap first
    task automatic send_density(input logic [DENS_W-1:0] d);
        if (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        density <= d;
        do
            @(posedge clk);
        while (!in_ready);
        predict_density(d);
        items_sent++;
    endtask

    // Hold off until every expected point has arrived and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_density();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom_range(32'h0004_0000);
            3: return $urandom;
            default: return $urandom_range(32'h0001_8000, 32'h0000_4000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(32'h0800_0000) - 32'h0400_0000;
    endfunction

    // Reset values: all coefficients zero, so each interior point passes through
    task automatic test_reset_state();
        for (int i = 0; i < 6; i++)
            send_density(i * 32'h0001_0000 + 32'h1234);
        drain();
    endtask

    // Three-point sweeps with extreme densities, ending the open sweep first
    task automatic test_short_sweep();
        write_all(2, 0, 0, 0, 0, 0, 0, 0);
        send_density(32'hFFFF_FFFF);
        send_density(32'h0);
        for (int i = 0; i < 6; i++)
            send_density(i[0] ? 32'hFFFF_FFFF : 32'h0);
        drain();
    endtask

    // Strong negative diffusion forces clamping; large growth forces saturation
    task automatic test_clamp_and_saturate();
        write_all(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++)
            send_density(i[0] ? 32'hFFFF_FFFF : 32'h0000_0001);
        drain();
        write_reg(REG_DIFFUSION, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_density(32'hFFFF_FFFF - i);
        drain();
    endtask

    // Realistic logistic growth with drift toward a centre
    task automatic test_typical_step();
        write_all(4095, 32'h0100_0000, 32'h0010_0000, 32'hFF00_0000, 32'h0001_0000,
                  32'h0800_0000, 32'h0000_8000, 32'h0002_0000);
        for (int i = 0; i < 12; i++)
            send_density(32'h0000_8000 + i * 32'h0000_1000);
        drain();
        write_reg(REG_LAST_INDEX, 3);
        send_density(32'h0001_0000);
        send_density(32'h0002_0000);
        drain();
    endtask

    // Random phases of mostly short sweeps with random coefficients
    task automatic test_random_sweeps(input int total);
        int phase;
        phase = 0;
        while (items_sent < total)
        begin
            write_all($urandom_range(8) == 0 ? $urandom_range(4095, 40) : $urandom_range(12, 2),
                      rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      $urandom_range(4) == 0 ? $urandom : $urandom_range(32'h0002_0000),
                      $urandom_range(4) == 0 ? $urandom : rand_coef());
            calm = (phase == 3);
            for (int i = 0; i < 55 && items_sent < total; i++)
                send_density(rand_density());
            calm = 1'b0;
            drain();
            phase++;
        end
    endtask

    // Receiver: random stalls except during the calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 22);

    // Compare each accepted point with the oldest expectation
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point idx %0d density %h", $time,
                         point_index, new_density);
            end
            else
            begin
                e = expected_points.pop_front();
                points_checked++;
                if (clamped) clamps_seen++;
                if (last_of_sweep) sweeps_seen++;
                if (new_density !== e.dens)
                begin
                    errors++;
                    $display("%0t: new_density expected %h actual %h", $time, e.dens,
                             new_density);
                end
                if (point_index !== e.idx)
                begin
                    errors++;
                    $display("%0t: point_index expected %0d actual %0d", $time, e.idx,
                             point_index);
                end
                if (clamped !== e.clp)
                begin
                    errors++;
                    $display("%0t: clamped expected %b actual %b", $time, e.clp, clamped);
                end
                if (last_of_sweep !== e.last)
                begin
                    errors++;
                    $display("%0t: last_of_sweep expected %b actual %b", $time, e.last,
                             last_of_sweep);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d points outstanding", cycles,
                     expected_points.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        m_last = 4095;
        m_growth = 0; m_invcap = 0; m_drift = 0; m_advect = 0; m_diff = 0;
        m_step = 0; m_origin = 0;
        m_prev = 0; m_prev2 = 0; m_count = 0; m_pos = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_short_sweep();
        test_clamp_and_saturate();
        test_typical_step();
        test_random_sweeps(items_sent + 510);
        $display("Sent %0d densities; checked %0d points, %0d clamped, %0d sweep ends.",
                 items_sent, points_checked, clamps_seen, sweeps_seen);
        if (errors == 0 && expected_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/rad_pkg.sv
hw/rtl/rad_front.sv
hw/rtl/rad_queue.sv
hw/rtl/rad_back.sv
hw/rtl/reaction_advection_diffusion_stencil.sv
hw/rtl/rad_checker.sv
bench/tb_reaction_advection_diffusion_stencil.sv
